// ----- sv/sequence_credit_window_defines.svh -----
// assertion helpers for the credit window block
`ifndef SEQUENCE_CREDIT_WINDOW_DEFINES_SVH
`define SEQUENCE_CREDIT_WINDOW_DEFINES_SVH

// same-cycle implication, idle while reset is low
`define SCW_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, idle while reset is low
`define SCW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/scw_pkg.sv -----
`default_nettype none
package scw_pkg;

	localparam int WINDOW = 32;
	localparam int CNT_W = 64;
	localparam int CREDIT_W = 6;

	localparam logic [CNT_W-1:0] WINDOW_W = CNT_W'(WINDOW);
	localparam logic [CREDIT_W-1:0] WINDOW_LOW = CREDIT_W'(WINDOW);
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	localparam logic [1:0] OP_ACK = 2'd0;
	localparam logic [1:0] OP_ASSIGN = 2'd1;
	localparam logic [1:0] OP_WRITTEN = 2'd2;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_INVALID = 2'd1,
		ST_EXHAUSTED = 2'd2,
		ST_WAIT = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0] operation;
		logic [CNT_W-1:0] ack_generation;
		logic [CNT_W-1:0] sequence_req;
	} req_t;

	typedef struct packed {
		status_t status;
		logic [CNT_W-1:0] assigned_sequence;
		logic [CREDIT_W-1:0] credit_left;
	} rsp_t;

	typedef struct packed {
		logic [CNT_W-1:0] assigned;
		logic [CNT_W-1:0] written;
		logic [CNT_W-1:0] acked;
		logic started;
		logic failed;
	} state_t;

endpackage
`default_nettype wire

// ----- sv/scw_step.sv -----
`default_nettype none
module scw_step import scw_pkg::*; (
	input wire state_t cur,
	input wire logic [CNT_W-1:0] generation,
	input wire req_t item,
	output state_t nxt,
	output rsp_t result
);

	logic gen_zero;
	logic failed_now;
	logic [CNT_W-1:0] outstanding;
	logic [CNT_W-1:0] outstanding_nxt;
	status_t status;
	logic [CNT_W-1:0] given;

	assign gen_zero = (generation == '0);
	assign failed_now = cur.failed || gen_zero;
	assign outstanding = cur.assigned - cur.acked;

	always_comb begin
		nxt = cur;
		status = ST_OK;
		given = '0;
		case (item.operation)
			OP_ACK: begin
				if (failed_now || item.ack_generation != generation) begin
					nxt.failed = 1'b1;
					status = ST_INVALID;
				end else if (!cur.started) begin
					// only sequence zero opens the window
					if (item.sequence_req != '0) begin
						nxt.failed = 1'b1;
						status = ST_INVALID;
					end else begin
						nxt.started = 1'b1;
					end
				end else if (item.sequence_req > cur.written) begin
					nxt.failed = 1'b1;
					status = ST_INVALID;
				end else if (item.sequence_req > cur.acked) begin
					nxt.acked = item.sequence_req;
				end
			end
			OP_ASSIGN: begin
				if (failed_now) begin
					nxt.failed = 1'b1;
					status = ST_INVALID;
				end else if (cur.assigned == CNT_MAX) begin
					nxt.failed = 1'b1;
					status = ST_EXHAUSTED;
				end else if (!cur.started || outstanding >= WINDOW_W) begin
					status = ST_WAIT;
				end else begin
					nxt.assigned = cur.assigned + CNT_W'(1);
					given = cur.assigned + CNT_W'(1);
				end
			end
			OP_WRITTEN: begin
				if (failed_now || cur.written == CNT_MAX ||
				    item.sequence_req != cur.written + CNT_W'(1) ||
				    item.sequence_req > cur.assigned) begin
					nxt.failed = 1'b1;
					status = ST_INVALID;
				end else begin
					nxt.written = item.sequence_req;
				end
			end
			default: begin
				status = ST_INVALID;
			end
		endcase
	end

	assign outstanding_nxt = nxt.assigned - nxt.acked;

	always_comb begin
		result.status = status;
		result.assigned_sequence = given;
		if (nxt.failed || gen_zero || !nxt.started || outstanding_nxt >= WINDOW_W) begin
			result.credit_left = '0;
		end else begin
			// low bits suffice, the output is masked to its width
			result.credit_left = WINDOW_LOW - outstanding_nxt[CREDIT_W-1:0];
		end
	end

endmodule
`default_nettype wire

// ----- sv/sequence_credit_window.sv -----
// Credit window tracker: each request is an acknowledge, an assign or a written
// report, and each gives exactly one response with status, the handed-out
// sequence and the credit left after the step. One request is taken every clock
// cycle unless req_stall holds it off while a stalled response blocks the input
// register; a request sits in the input register while the step logic (64-bit
// compares, increments and the outstanding subtractions) updates the counters
// and loads the response register, which drives the response outputs. Writing
// the generation register clears all counters and flags at once; a generation
// of zero keeps the block failed. Write it only while no request is in flight.
`default_nettype none
`include "sequence_credit_window_defines.svh"
module sequence_credit_window import scw_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_stall,
	input wire req_t req,
	output logic rsp_valid,
	input wire logic rsp_stall,
	output rsp_t rsp,
	input wire logic cfg_wr_en,
	input wire logic [CNT_W-1:0] cfg_wr_data
);

	logic [CNT_W-1:0] generation_q;
	state_t state_q;
	state_t state_nxt;
	logic valid_s1;
	req_t req_s1;
	logic rsp_valid_q;
	rsp_t rsp_q;
	rsp_t rsp_nxt;
	logic advance;
	logic accept_req;

	assign advance = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !advance;
	assign accept_req = req_valid && !req_stall;

	scw_step u_step (
		.cur(state_q),
		.generation(generation_q),
		.item(req_s1),
		.nxt(state_nxt),
		.result(rsp_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			generation_q <= '0;
			state_q <= '0;
			valid_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				generation_q <= cfg_wr_data;
				state_q <= '{assigned: '0, written: '0, acked: '0, started: 1'b0,
					failed: (cfg_wr_data == '0)};
			end else if (advance) begin
				state_q <= state_nxt;
			end
			if (accept_req) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept_req) begin
			req_s1 <= req;
		end
		if (advance) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	// acknowledged never passes written, written never passes assigned
	`SCW_ASSERT_NOW(a_count_order, 1'b1, state_q.acked <= state_q.written && state_q.written <= state_q.assigned, "counter order broken")
	// failure latches until the generation register is written
	`SCW_ASSERT_NEXT(a_fail_latch, state_q.failed && !cfg_wr_en, state_q.failed, "failed flag dropped")
	// a handed-out sequence only comes with an ok status
	`SCW_ASSERT_NOW(a_given_ok, rsp_valid_q && rsp_q.assigned_sequence != '0, rsp_q.status == ST_OK, "sequence given without ok")

endmodule
`default_nettype wire
